// ===== src/pidr_pkg.sv =====
// pidr_pkg: types, codes and saturation helpers for the PID controller.
// Used by pidr_muldiv and pid_with_deadzone_ramp.
package pidr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 96;   // widest product / dividend
    localparam int MCAND_W   = 64;   // multiplicand width
    localparam int MPLR_W    = 32;   // multiplier width
    localparam int DIVR_W    = 48;   // divisor width
    localparam int CNT_W     = 7;

    // register indexes on the config port
    localparam logic [2:0] REG_GAIN_P     = 3'd0;
    localparam logic [2:0] REG_GAIN_I     = 3'd1;
    localparam logic [2:0] REG_GAIN_D     = 3'd2;
    localparam logic [2:0] REG_OUT_LIMIT  = 3'd3;
    localparam logic [2:0] REG_SLEW_LIMIT = 3'd4;
    localparam logic [2:0] REG_DEAD_BAND  = 3'd5;
    localparam logic [2:0] REG_RUN_ENABLE = 3'd6;

    // result status codes
    localparam logic [1:0] ST_COMPUTED = 2'd0;
    localparam logic [1:0] ST_PRIMING  = 2'd1;
    localparam logic [1:0] ST_DISABLED = 2'd2;
    localparam logic [1:0] ST_CLEARED  = 2'd3;

    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic start;
        logic div;     // 1: divide, 0: multiply
    } mdu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mdu_stat_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : v;
    endfunction

    // signed result of a magnitude quotient, saturated to 32 bits
    function automatic logic signed [31:0] sat_q(input logic [PROD_W-1:0] q,
                                                 input logic neg);
        if (neg)
            sat_q = (q > PROD_W'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-q[31:0]);
        else
            sat_q = (q > PROD_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[31:0];
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF)
            sat34 = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            sat34 = 32'sh8000_0000;
        else
            sat34 = v[31:0];
    endfunction

    // symmetric clamp; a limit of zero leaves the value alone
    function automatic logic signed [31:0] clamp(input logic signed [31:0] v,
                                                 input logic [30:0] lim);
        logic signed [32:0] vs;
        logic signed [32:0] ls;
        vs = {v[31], v};
        ls = $signed({2'b00, lim});
        if (lim == '0)
            clamp = v;
        else if (vs > ls)
            clamp = {1'b0, lim};
        else if (vs < -ls)
            clamp = 32'(-ls);
        else
            clamp = v;
    endfunction

endpackage

// ===== src/pid_with_deadzone_ramp.sv =====
// pid_with_deadzone_ramp: PID controller top level, sequencer and state.
// Depends on pidr_pkg and pidr_muldiv.
//
//  channel | direction | handshake          | content
//  s_*     | in        | s_tvalid/s_tready  | tdata err_sample, stamp_ms; tuser func
//  m_*     | out       | m_tvalid/m_tready  | tdata drive; tuser status
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// Clear, priming and disabled beats go from S_DEC straight to S_OUT and the output register.
// A computed beat runs five multiplies of 32 steps and two divides of 96 steps
// on the one serial multiply/divide unit; the ramp adds one more of each.
// Reset (rst_n, asynchronous) clears history, stamp and config (run_enable 1).
// s_tready is high only while the sequencer is idle; a result held on a
// stalled m side does not stop the next beat being taken.
module pid_with_deadzone_ramp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [31:0] err_sample, [63:32] stamp_ms
    input  logic        s_tuser,     // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] drive
    output logic [1:0]  m_tuser,     // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pidr_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_RAMP  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // operation steps on the shared unit
    localparam logic [3:0] OP_P_MUL  = 4'd0;
    localparam logic [3:0] OP_I_MUL1 = 4'd1;
    localparam logic [3:0] OP_I_MUL2 = 4'd2;
    localparam logic [3:0] OP_I_DIV  = 4'd3;
    localparam logic [3:0] OP_D_MUL1 = 4'd4;
    localparam logic [3:0] OP_D_MUL2 = 4'd5;
    localparam logic [3:0] OP_D_DIV  = 4'd6;
    localparam logic [3:0] OP_R_MUL  = 4'd7;
    localparam logic [3:0] OP_R_DIV  = 4'd8;

    // config registers
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0]        out_limit_reg, slew_limit_reg, dead_band_reg;
    logic               run_enable_reg;

    // controller history
    logic [31:0]        prev_stamp_reg, prev_stamp_next;
    logic signed [31:0] prev_error_reg, prev_error_next;
    logic signed [31:0] integ_acc_reg, integ_acc_next;
    logic signed [31:0] prev_drive_reg, prev_drive_next;

    // sequencer and working registers
    logic [2:0]         state_reg, state_next;
    logic [3:0]         step_reg, step_next;
    logic               func_reg, func_next;
    logic signed [31:0] err_reg, err_next;
    logic [31:0]        stamp_reg, stamp_next;
    logic [31:0]        dt_reg, dt_next;
    logic signed [31:0] e_reg, e_next;
    logic signed [31:0] p_reg, p_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [31:0] d_reg, d_next;
    logic signed [31:0] o_reg, o_next;
    logic [62:0]        budget_reg, budget_next;
    logic [31:0]        rstep_reg, rstep_next;
    logic signed [31:0] res_drive_reg, res_drive_next;
    logic [1:0]         res_status_reg, res_status_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_data_reg, m_data_next;
    logic [1:0]         m_user_reg, m_user_next;

    // shared unit
    mdu_cmd_t           mdu_cmd;
    mdu_stat_t          mdu_stat;
    logic [95:0]        mdu_opa;
    logic [47:0]        mdu_opb;
    logic [95:0]        mdu_res;

    // combinational helpers
    logic [31:0]        dt_raw;
    logic signed [32:0] es, dbs;
    logic signed [31:0] e_db;
    logic signed [32:0] e_sum, e_dif;
    logic               neg_p, neg_i, neg_d;
    logic signed [31:0] i_term;
    logic signed [32:0] integ_wide;
    logic signed [31:0] o_sum;
    logic signed [32:0] diff;
    logic signed [63:0] diff64, diff1000, budget_s;
    logic signed [31:0] o_ramp;

    pidr_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mdu_cmd),
        .opa   (mdu_opa),
        .opb   (mdu_opb),
        .res   (mdu_res),
        .stat  (mdu_stat)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            out_limit_reg  <= '0;
            slew_limit_reg <= '0;
            dead_band_reg  <= '0;
            run_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN_P:     gain_p_reg     <= cfg_data;
                REG_GAIN_I:     gain_i_reg     <= cfg_data;
                REG_GAIN_D:     gain_d_reg     <= cfg_data;
                REG_OUT_LIMIT:  out_limit_reg  <= cfg_data[30:0];
                REG_SLEW_LIMIT: slew_limit_reg <= cfg_data[30:0];
                REG_DEAD_BAND:  dead_band_reg  <= cfg_data[30:0];
                REG_RUN_ENABLE: run_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // dead band, elapsed time and term signs
    always_comb
    begin
        dt_raw = stamp_reg - prev_stamp_reg;
        es     = {err_reg[31], err_reg};
        dbs    = $signed({2'b00, dead_band_reg});
        e_db   = (dead_band_reg != '0 && es < dbs && es > -dbs) ? '0 : err_reg;
        e_sum  = {e_reg[31], e_reg} + {prev_error_reg[31], prev_error_reg};
        e_dif  = {e_reg[31], e_reg} - {prev_error_reg[31], prev_error_reg};
        neg_p  = e_reg[31] != gain_p_reg[31];
        neg_i  = e_sum[32] != gain_i_reg[31];
        neg_d  = e_dif[32] != gain_d_reg[31];
    end

    // operand selection for the shared unit
    always_comb
    begin
        mdu_cmd.start = (state_reg == S_ISSUE);
        mdu_cmd.div   = 1'b0;
        mdu_opa       = mdu_res;
        mdu_opb       = '0;
        case (step_reg)
            OP_P_MUL:
            begin
                mdu_opa = {64'd0, mag32(e_reg)};
                mdu_opb = {16'd0, mag32(gain_p_reg)};
            end
            OP_I_MUL1:
            begin
                mdu_opa = {63'd0, mag33(e_sum)};
                mdu_opb = {16'd0, mag32(gain_i_reg)};
            end
            OP_I_MUL2: mdu_opb = {16'd0, dt_reg};
            OP_I_DIV:
            begin
                mdu_cmd.div = 1'b1;
                mdu_opb     = 48'd131072000;   // 2000 ms scaled by 2^16
            end
            OP_D_MUL1:
            begin
                mdu_opa = {63'd0, mag33(e_dif)};
                mdu_opb = {16'd0, mag32(gain_d_reg)};
            end
            OP_D_MUL2: mdu_opb = 48'd1000;
            OP_D_DIV:
            begin
                mdu_cmd.div = 1'b1;
                mdu_opb     = {dt_reg, 16'd0};
            end
            OP_R_MUL:
            begin
                mdu_opa = {65'd0, slew_limit_reg};
                mdu_opb = {16'd0, dt_reg};
            end
            OP_R_DIV:
            begin
                mdu_cmd.div = 1'b1;
                mdu_opb     = 48'd1000;
            end
            default: ;
        endcase
    end

    // output sum, clamp and ramp
    always_comb
    begin
        i_term     = sat_q(mdu_res, neg_i);
        integ_wide = {integ_acc_reg[31], integ_acc_reg} + {i_term[31], i_term};
        o_sum      = clamp(sat34({{2{p_reg[31]}}, p_reg}
                                 + {{2{integ_reg[31]}}, integ_reg}
                                 + {{2{d_reg[31]}}, d_reg}), out_limit_reg);
        diff       = {o_reg[31], o_reg} - {prev_drive_reg[31], prev_drive_reg};
        diff64     = {{31{diff[32]}}, diff};
        diff1000   = (diff64 <<< 10) - (diff64 <<< 4) - (diff64 <<< 3);
        budget_s   = $signed({1'b0, budget_reg});
        if (diff1000 > budget_s)
            o_ramp = sat34({{2{prev_drive_reg[31]}}, prev_drive_reg}
                           + {2'b00, rstep_reg});
        else if (diff1000 < -budget_s)
            o_ramp = sat34({{2{prev_drive_reg[31]}}, prev_drive_reg}
                           - {2'b00, rstep_reg});
        else
            o_ramp = o_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        func_next       = func_reg;
        err_next        = err_reg;
        stamp_next      = stamp_reg;
        dt_next         = dt_reg;
        e_next          = e_reg;
        p_next          = p_reg;
        integ_next      = integ_reg;
        d_next          = d_reg;
        o_next          = o_reg;
        budget_next     = budget_reg;
        rstep_next      = rstep_reg;
        res_drive_next  = res_drive_reg;
        res_status_next = res_status_reg;
        prev_stamp_next = prev_stamp_reg;
        prev_error_next = prev_error_reg;
        integ_acc_next  = integ_acc_reg;
        prev_drive_next = prev_drive_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    err_next   = s_tdata[31:0];
                    stamp_next = s_tdata[63:32];
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                res_drive_next = '0;
                state_next     = S_OUT;
                if (func_reg == FUNC_CLEAR)
                begin
                    prev_error_next = '0;
                    integ_acc_next  = '0;
                    prev_drive_next = '0;
                    res_status_next = ST_CLEARED;
                end
                else if (prev_stamp_reg == '0)
                begin
                    prev_stamp_next = stamp_reg;
                    res_status_next = ST_PRIMING;
                end
                else
                begin
                    prev_stamp_next = stamp_reg;
                    dt_next         = (dt_raw == '0) ? 32'd1 : dt_raw;
                    if (!run_enable_reg)
                    begin
                        prev_error_next = '0;
                        integ_acc_next  = '0;
                        prev_drive_next = '0;
                        res_status_next = ST_DISABLED;
                    end
                    else
                    begin
                        e_next          = e_db;
                        res_status_next = ST_COMPUTED;
                        step_next       = OP_P_MUL;
                        state_next      = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
                state_next = S_WAIT;
            S_WAIT:
            begin
                if (mdu_stat.done)
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_ISSUE;
                    case (step_reg)
                        OP_P_MUL:
                            p_next = sat_q({16'd0, mdu_res[95:FRAC_BITS]}, neg_p);
                        OP_I_DIV:
                            integ_next = clamp(sat34({integ_wide[32], integ_wide}),
                                               out_limit_reg);
                        OP_D_DIV:
                        begin
                            d_next     = sat_q(mdu_res, neg_d);
                            state_next = S_SUM;
                        end
                        OP_R_MUL:
                            budget_next = mdu_res[62:0];
                        OP_R_DIV:
                        begin
                            rstep_next = sat_q(mdu_res, 1'b0);
                            state_next = S_RAMP;
                        end
                        default: ;
                    endcase
                end
            end
            S_SUM:
            begin
                if (slew_limit_reg != '0)
                begin
                    o_next     = o_sum;
                    step_next  = OP_R_MUL;
                    state_next = S_ISSUE;
                end
                else
                begin
                    integ_acc_next  = integ_reg;
                    prev_error_next = e_reg;
                    prev_drive_next = o_sum;
                    res_drive_next  = o_sum;
                    state_next      = S_OUT;
                end
            end
            S_RAMP:
            begin
                integ_acc_next  = integ_reg;
                prev_error_next = e_reg;
                prev_drive_next = o_ramp;
                res_drive_next  = o_ramp;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_drive_reg;
                    m_user_next  = res_status_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= OP_P_MUL;
            m_valid_reg    <= 1'b0;
            prev_stamp_reg <= '0;
            prev_error_reg <= '0;
            integ_acc_reg  <= '0;
            prev_drive_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            m_valid_reg    <= m_valid_next;
            prev_stamp_reg <= prev_stamp_next;
            prev_error_reg <= prev_error_next;
            integ_acc_reg  <= integ_acc_next;
            prev_drive_reg <= prev_drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        err_reg        <= err_next;
        stamp_reg      <= stamp_next;
        dt_reg         <= dt_next;
        e_reg          <= e_next;
        p_reg          <= p_next;
        integ_reg      <= integ_next;
        d_reg          <= d_next;
        o_reg          <= o_next;
        budget_reg     <= budget_next;
        rstep_reg      <= rstep_next;
        res_drive_reg  <= res_drive_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    // the unit must be quiet whenever a new beat can be taken
    a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mdu_stat.busy)
        else $error("unit busy while idle");

    // a taken beat closes the input until its result is queued
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken during work");

    // results of the unit only arrive while the sequencer waits for them
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mdu_stat.done |-> state_reg == S_WAIT)
        else $error("unit done outside wait");

endmodule

// ===== src/pidr_muldiv.sv =====
// pidr_muldiv: shared bit-serial unit, shift-add multiply (32 steps)
// or restoring divide (96 steps). Depends on pidr_pkg.
module pidr_muldiv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pidr_pkg::mdu_cmd_t        cmd,
    input  logic [95:0]               opa,
    input  logic [47:0]               opb,
    output logic [95:0]               res,
    output pidr_pkg::mdu_stat_t       stat
);
    import pidr_pkg::*;

    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [MCAND_W-1:0] a_reg, a_next;
    logic [DIVR_W-1:0]  b_reg, b_next;
    logic [DIVR_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               div_reg, div_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIVR_W:0]    trial;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DIVR_W-1:0], acc_reg[PROD_W-1]};
        if (cmd.start)
        begin
            div_next  = cmd.div;
            acc_next  = cmd.div ? opa : '0;
            a_next    = opa[MCAND_W-1:0];
            b_next    = cmd.div ? opb : {opb[MPLR_W-1:0], 16'd0};
            rem_next  = '0;
            cnt_next  = cmd.div ? CNT_W'(PROD_W) : CNT_W'(MPLR_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (trial >= {1'b0, b_reg})
                begin
                    rem_next = trial - {1'b0, b_reg};
                    acc_next = {acc_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    acc_next = {acc_reg[PROD_W-2:0], 1'b0};
                end
            end
            else
            begin
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + (b_reg[DIVR_W-1] ? {32'd0, a_reg} : '0);
                b_next   = {b_reg[DIVR_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign res       = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
